FILE: hdl/qlcm_pkg.sv
// Shared types and constants for the queued lock and condition manager.
package qlcm_pkg;

  // Request operation after classification of the kind field
  typedef enum logic [3:0] {
    OP_LOCK_CREATE  = 4'd0,
    OP_ACQUIRE      = 4'd1,
    OP_RELEASE      = 4'd2,
    OP_LOCK_DESTROY = 4'd3,
    OP_COND_CREATE  = 4'd4,
    OP_SIGNAL       = 4'd5,
    OP_WAIT         = 4'd6,
    OP_BROADCAST    = 4'd7,
    OP_COND_DESTROY = 4'd8,
    OP_NONE         = 4'd15
  } op_t;

  // Classified request as it travels through the request queue
  typedef struct packed {
    op_t         op;
    logic [15:0] who;
    logic [7:0]  lock_id;
    logic [7:0]  cond_id;
    logic [31:0] key;
    logic        lock_ok;
    logic        cond_ok;
  } req_t;

  // Sequencer states of the execution unit
  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_STAT,
    S_SCAN_A,
    S_SCAN_B,
    S_CR_HIT,
    S_CR_NEW,
    S_EXEC,
    S_TAKE,
    S_G_RD,
    S_G_DATA,
    S_REL_OK,
    S_POP_RD,
    S_POP_DATA,
    S_SIG_OK,
    S_BC_LOOP
  } state_t;

  localparam logic [7:0] REFS_MAX = 8'd255;

endpackage

FILE: hdl/qlcm_ram.sv
// Generic single-write, single-read RAM with registered read data.
module qlcm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hdl/qlcm_front.sv
// Request intake: classifies each request and holds it in a two-entry queue.
module qlcm_front #(
  parameter int NUM_LOCKS = 16,
  parameter int NUM_CONDS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [3:0]          kind,
  input  logic [7:0]          client_machine,
  input  logic [7:0]          client_mailbox,
  input  logic [7:0]          lock_index,
  input  logic [7:0]          cond_index,
  input  logic [31:0]         name_key,
  output logic                q_valid,
  output qlcm_pkg::req_t      q_req,
  input  logic                q_pop
);
  import qlcm_pkg::*;

  req_t       cls;
  req_t       slot [2];
  logic       rd_ptr;
  logic       wr_ptr;
  logic [1:0] fill;
  logic       push;

  // Classify the incoming request
  always_comb begin
    cls.who     = {client_machine, client_mailbox};
    cls.lock_id = lock_index;
    cls.cond_id = cond_index;
    cls.key     = name_key;
    cls.lock_ok = 9'(lock_index) < 9'(NUM_LOCKS);
    cls.cond_ok = 9'(cond_index) < 9'(NUM_CONDS);
    unique case (kind)
      4'd0:    cls.op = OP_LOCK_CREATE;
      4'd1:    cls.op = OP_ACQUIRE;
      4'd2:    cls.op = OP_RELEASE;
      4'd3:    cls.op = OP_LOCK_DESTROY;
      4'd4:    cls.op = OP_COND_CREATE;
      4'd5:    cls.op = OP_SIGNAL;
      4'd6:    cls.op = OP_WAIT;
      4'd7:    cls.op = OP_BROADCAST;
      4'd8:    cls.op = OP_COND_DESTROY;
      default: cls.op = OP_NONE;
    endcase
  end

  assign in_stall = (fill == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (fill != 2'd0);
  assign q_req    = slot[rd_ptr];

  // Queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= cls;
    end
  end

  // Queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      fill <= fill + 2'(push) - 2'(q_pop);
    end
  end

endmodule

FILE: hdl/qlcm_back.sv
// Execution unit: applies requests to the lock and condition tables and issues replies.
module qlcm_back #(
  parameter int NUM_LOCKS   = 16,
  parameter int NUM_CONDS   = 16,
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_valid,
  input  qlcm_pkg::req_t      q_req,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [7:0]          dest_machine,
  output logic [7:0]          dest_mailbox,
  output logic                failed,
  output logic [3:0]          entry_index,
  output logic                last
);
  import qlcm_pkg::*;

  localparam int LIW = (NUM_LOCKS > 1) ? $clog2(NUM_LOCKS) : 1;
  localparam int CIW = (NUM_CONDS > 1) ? $clog2(NUM_CONDS) : 1;
  localparam int SW  = (LIW > CIW) ? LIW : CIW;
  localparam int QW  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam logic [LIW:0]  NONE_LOCK = (LIW + 1)'(NUM_LOCKS);
  localparam logic [QW:0]   QD        = (QW + 1)'(QUEUE_DEPTH);
  localparam logic [QW-1:0] QD_LAST   = QW'(QUEUE_DEPTH - 1);

  typedef struct packed {
    logic [7:0]    refs;
    logic          busy;
    logic [15:0]   owner;
    logic [QW-1:0] head;
    logic [QW:0]   count;
  } lstat_t;

  typedef struct packed {
    logic [7:0]    refs;
    logic [LIW:0]  bound;
    logic [QW-1:0] head;
    logic [QW:0]   count;
  } cstat_t;

  state_t         st, st_next;
  req_t           rq, rq_next;
  lstat_t         ls, ls_next;
  cstat_t         cs, cs_next;
  logic [15:0]    tw, tw_next;
  logic           tlast, tlast_next;
  state_t         tnext, tnext_next;
  logic           glast, glast_next;
  state_t         gnext, gnext_next;
  logic [SW-1:0]  scan, scan_next;
  logic [SW-1:0]  free_idx, free_idx_next;
  logic           free_seen, free_seen_next;

  logic [NUM_LOCKS-1:0] lvalid;
  logic [NUM_CONDS-1:0] cvalid;
  logic           lv_set, lv_clr, cv_set, cv_clr;
  logic [LIW-1:0] lv_idx;
  logic [CIW-1:0] cv_idx;

  logic           emit, e_fail, e_last;
  logic [15:0]    e_who;
  logic [3:0]     e_idx;
  logic           can_emit;

  logic [LIW-1:0] l_idx;
  logic [CIW-1:0] c_idx;
  logic [LIW-1:0] scan_l;
  logic [CIW-1:0] scan_c;
  logic           is_lock_create;

  // RAM ports
  logic           lname_we;
  logic [31:0]    lname_rdata;
  logic           cname_we;
  logic [31:0]    cname_rdata;
  logic           lstat_we;
  logic [LIW-1:0] lstat_waddr, lstat_raddr;
  lstat_t         lstat_wdata, lstat_rdata;
  logic           cstat_we;
  logic [CIW-1:0] cstat_waddr, cstat_raddr;
  cstat_t         cstat_wdata, cstat_rdata;
  logic           lwait_we;
  logic [LIW+QW-1:0] lwait_waddr;
  logic [15:0]    lwait_rdata;
  logic           cwait_we;
  logic [CIW+QW-1:0] cwait_waddr;
  logic [15:0]    cwait_rdata;
  logic [QW-1:0]  lslot, cslot;

  assign l_idx          = rq.lock_id[LIW-1:0];
  assign c_idx          = rq.cond_id[CIW-1:0];
  assign scan_l         = scan[LIW-1:0];
  assign scan_c         = scan[CIW-1:0];
  assign is_lock_create = (rq.op == OP_LOCK_CREATE);
  assign can_emit       = !out_valid || !out_stall;

  // Tail slots of the waiter rings
  always_comb begin
    logic [QW+1:0] ls_sum;
    logic [QW+1:0] cs_sum;
    ls_sum = (QW + 2)'(ls.head) + (QW + 2)'(ls.count);
    cs_sum = (QW + 2)'(cs.head) + (QW + 2)'(cs.count);
    if (ls_sum >= (QW + 2)'(QUEUE_DEPTH)) begin
      ls_sum = ls_sum - (QW + 2)'(QUEUE_DEPTH);
    end
    if (cs_sum >= (QW + 2)'(QUEUE_DEPTH)) begin
      cs_sum = cs_sum - (QW + 2)'(QUEUE_DEPTH);
    end
    lslot = ls_sum[QW-1:0];
    cslot = cs_sum[QW-1:0];
  end

  // Read addresses: scanning walks the tables, otherwise the named entries
  assign lstat_raddr = (st == S_SCAN_B || st == S_CR_HIT) ? scan_l : l_idx;
  assign cstat_raddr = (st == S_SCAN_B || st == S_CR_HIT) ? scan_c : c_idx;

  qlcm_ram #(.WIDTH(32), .DEPTH(NUM_LOCKS)) u_lname (
    .clk(clk), .we(lname_we), .waddr(free_idx[LIW-1:0]), .wdata(rq.key),
    .raddr(scan_l), .rdata(lname_rdata)
  );

  qlcm_ram #(.WIDTH(32), .DEPTH(NUM_CONDS)) u_cname (
    .clk(clk), .we(cname_we), .waddr(free_idx[CIW-1:0]), .wdata(rq.key),
    .raddr(scan_c), .rdata(cname_rdata)
  );

  qlcm_ram #(.WIDTH($bits(lstat_t)), .DEPTH(NUM_LOCKS)) u_lstat (
    .clk(clk), .we(lstat_we), .waddr(lstat_waddr), .wdata(lstat_wdata),
    .raddr(lstat_raddr), .rdata(lstat_rdata)
  );

  qlcm_ram #(.WIDTH($bits(cstat_t)), .DEPTH(NUM_CONDS)) u_cstat (
    .clk(clk), .we(cstat_we), .waddr(cstat_waddr), .wdata(cstat_wdata),
    .raddr(cstat_raddr), .rdata(cstat_rdata)
  );

  qlcm_ram #(.WIDTH(16), .DEPTH(2 ** (LIW + QW))) u_lwait (
    .clk(clk), .we(lwait_we), .waddr(lwait_waddr), .wdata(tw),
    .raddr({l_idx, ls.head}), .rdata(lwait_rdata)
  );

  qlcm_ram #(.WIDTH(16), .DEPTH(2 ** (CIW + QW))) u_cwait (
    .clk(clk), .we(cwait_we), .waddr(cwait_waddr), .wdata(rq.who),
    .raddr({c_idx, cs.head}), .rdata(cwait_rdata)
  );

  // State register and working copies
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= S_IDLE;
    end else begin
      st <= st_next;
    end
    rq        <= rq_next;
    ls        <= ls_next;
    cs        <= cs_next;
    tw        <= tw_next;
    tlast     <= tlast_next;
    tnext     <= tnext_next;
    glast     <= glast_next;
    gnext     <= gnext_next;
    scan      <= scan_next;
    free_idx  <= free_idx_next;
    free_seen <= free_seen_next;
  end

  // Entry valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      lvalid <= '0;
      cvalid <= '0;
    end else begin
      if (lv_set) lvalid[lv_idx] <= 1'b1;
      if (lv_clr) lvalid[lv_idx] <= 1'b0;
      if (cv_set) cvalid[cv_idx] <= 1'b1;
      if (cv_clr) cvalid[cv_idx] <= 1'b0;
    end
  end

  // Reply register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (emit) begin
      dest_machine <= e_who[15:8];
      dest_mailbox <= e_who[7:0];
      failed       <= e_fail;
      entry_index  <= e_idx;
      last         <= e_last;
    end
  end

  // Sequencer
  always_comb begin
    logic         hit_v;
    logic [31:0]  hit_nm;
    logic [7:0]   hit_refs;
    logic [7:0]   idx8;
    logic [LIW:0] bnd;
    logic [LIW:0] l_ext;

    st_next        = st;
    rq_next        = rq;
    ls_next        = ls;
    cs_next        = cs;
    tw_next        = tw;
    tlast_next     = tlast;
    tnext_next     = tnext;
    glast_next     = glast;
    gnext_next     = gnext;
    scan_next      = scan;
    free_idx_next  = free_idx;
    free_seen_next = free_seen;
    q_pop          = 1'b0;
    lv_set = 1'b0; lv_clr = 1'b0; lv_idx = l_idx;
    cv_set = 1'b0; cv_clr = 1'b0; cv_idx = c_idx;
    emit = 1'b0; e_who = rq.who; e_fail = 1'b0; e_idx = 4'd0; e_last = 1'b1;
    lname_we = 1'b0;
    cname_we = 1'b0;
    lstat_we = 1'b0; lstat_waddr = l_idx; lstat_wdata = ls;
    cstat_we = 1'b0; cstat_waddr = c_idx; cstat_wdata = cs;
    lwait_we = 1'b0; lwait_waddr = {l_idx, lslot};
    cwait_we = 1'b0; cwait_waddr = {c_idx, cslot};
    hit_v    = is_lock_create ? lvalid[scan_l] : cvalid[scan_c];
    hit_nm   = is_lock_create ? lname_rdata : cname_rdata;
    hit_refs = is_lock_create ? lstat_rdata.refs : cstat_rdata.refs;
    idx8     = 8'(scan);
    l_ext    = {1'b0, l_idx};
    bnd      = (cs.bound == NONE_LOCK) ? l_ext : cs.bound;

    unique case (st)
      S_IDLE: begin
        if (q_valid) begin
          q_pop   = 1'b1;
          rq_next = q_req;
          st_next = S_DECODE;
        end
      end

      // Entry checks; the status reads for the named entries go out here
      S_DECODE: begin
        unique case (rq.op)
          OP_LOCK_CREATE, OP_COND_CREATE: begin
            scan_next      = '0;
            free_seen_next = 1'b0;
            st_next        = S_SCAN_A;
          end
          OP_ACQUIRE, OP_RELEASE, OP_LOCK_DESTROY: begin
            if (rq.lock_ok && lvalid[l_idx]) begin
              st_next = S_STAT;
            end else if (can_emit) begin
              emit = 1'b1; e_fail = 1'b1; st_next = S_IDLE;
            end
          end
          OP_COND_DESTROY: begin
            if (rq.cond_ok && cvalid[c_idx]) begin
              st_next = S_STAT;
            end else if (can_emit) begin
              emit = 1'b1; e_fail = 1'b1; st_next = S_IDLE;
            end
          end
          OP_SIGNAL, OP_WAIT, OP_BROADCAST: begin
            if (rq.lock_ok && rq.cond_ok && lvalid[l_idx] && cvalid[c_idx]) begin
              st_next = S_STAT;
            end else if (can_emit) begin
              emit = 1'b1; e_fail = 1'b1; st_next = S_IDLE;
            end
          end
          default: st_next = S_IDLE;
        endcase
      end

      S_STAT: begin
        ls_next = lstat_rdata;
        cs_next = cstat_rdata;
        st_next = S_EXEC;
      end

      S_SCAN_A: st_next = S_SCAN_B;

      // Name match ends the scan; otherwise note the lowest free slot
      S_SCAN_B: begin
        if (hit_v && hit_nm == rq.key) begin
          st_next = S_CR_HIT;
        end else begin
          if (!hit_v && !free_seen) begin
            free_seen_next = 1'b1;
            free_idx_next  = scan;
          end
          if ((is_lock_create && scan == SW'(NUM_LOCKS - 1)) ||
              (!is_lock_create && scan == SW'(NUM_CONDS - 1))) begin
            st_next = S_CR_NEW;
          end else begin
            scan_next = scan + SW'(1);
            st_next   = S_SCAN_A;
          end
        end
      end

      S_CR_HIT: begin
        if (can_emit) begin
          emit    = 1'b1;
          st_next = S_IDLE;
          if (hit_refs >= REFS_MAX) begin
            e_fail = 1'b1;
          end else begin
            e_idx = idx8[3:0];
            if (is_lock_create) begin
              lstat_we         = 1'b1;
              lstat_waddr      = scan_l;
              lstat_wdata      = lstat_rdata;
              lstat_wdata.refs = hit_refs + 8'd1;
            end else begin
              cstat_we         = 1'b1;
              cstat_waddr      = scan_c;
              cstat_wdata      = cstat_rdata;
              cstat_wdata.refs = hit_refs + 8'd1;
            end
          end
        end
      end

      S_CR_NEW: begin
        if (can_emit) begin
          emit    = 1'b1;
          st_next = S_IDLE;
          if (!free_seen) begin
            e_fail = 1'b1;
          end else begin
            idx8  = 8'(free_idx);
            e_idx = idx8[3:0];
            if (is_lock_create) begin
              lv_set      = 1'b1;
              lv_idx      = free_idx[LIW-1:0];
              lname_we    = 1'b1;
              lstat_we    = 1'b1;
              lstat_waddr = free_idx[LIW-1:0];
              lstat_wdata = '{refs: 8'd1, busy: 1'b0, owner: 16'd0, head: '0, count: '0};
            end else begin
              cv_set      = 1'b1;
              cv_idx      = free_idx[CIW-1:0];
              cname_we    = 1'b1;
              cstat_we    = 1'b1;
              cstat_waddr = free_idx[CIW-1:0];
              cstat_wdata = '{refs: 8'd1, bound: NONE_LOCK, head: '0, count: '0};
            end
          end
        end
      end

      S_EXEC: begin
        unique case (rq.op)
          OP_ACQUIRE: begin
            tw_next    = rq.who;
            tlast_next = 1'b1;
            tnext_next = S_IDLE;
            st_next    = S_TAKE;
          end
          OP_RELEASE: begin
            if (!(ls.busy && ls.owner == rq.who)) begin
              if (can_emit) begin
                emit = 1'b1; e_fail = 1'b1; st_next = S_IDLE;
              end
            end else if (ls.count != '0) begin
              glast_next = 1'b0;
              gnext_next = S_REL_OK;
              st_next    = S_G_RD;
            end else if (can_emit) begin
              emit        = 1'b1;
              lstat_we    = 1'b1;
              lstat_wdata = ls;
              lstat_wdata.busy = 1'b0;
              st_next     = S_IDLE;
            end
          end
          OP_LOCK_DESTROY: begin
            if (can_emit) begin
              emit             = 1'b1;
              lstat_we         = 1'b1;
              lstat_wdata      = ls;
              lstat_wdata.refs = ls.refs - 8'd1;
              if (ls.refs == 8'd1) begin
                lv_clr = 1'b1;
              end else begin
                e_fail = 1'b1;
              end
              st_next = S_IDLE;
            end
          end
          OP_COND_DESTROY: begin
            if (can_emit) begin
              emit             = 1'b1;
              cstat_we         = 1'b1;
              cstat_wdata      = cs;
              cstat_wdata.refs = cs.refs - 8'd1;
              if (cs.refs == 8'd1) begin
                cv_clr = 1'b1;
              end else begin
                e_fail = 1'b1;
              end
              st_next = S_IDLE;
            end
          end
          // Wait: bind, queue the client, then release the lock for it
          OP_WAIT: begin
            if (bnd != l_ext || cs.count >= QD) begin
              if (can_emit) begin
                emit              = 1'b1;
                e_fail            = 1'b1;
                cstat_we          = 1'b1;
                cstat_wdata       = cs;
                cstat_wdata.bound = bnd;
                st_next           = S_IDLE;
              end
            end else begin
              cwait_we      = 1'b1;
              cs_next.bound = bnd;
              cs_next.count = cs.count + (QW + 1)'(1);
              st_next       = S_BC_LOOP;
              if (ls.busy && ls.owner == rq.who) begin
                if (ls.count != '0) begin
                  glast_next = 1'b1;
                  gnext_next = S_SIG_OK;
                  st_next    = S_G_RD;
                end else begin
                  ls_next.busy = 1'b0;
                  gnext_next   = S_SIG_OK;
                  st_next      = S_SIG_OK;
                end
              end else begin
                gnext_next = S_SIG_OK;
                st_next    = S_SIG_OK;
              end
            end
          end
          OP_SIGNAL: begin
            if (cs.bound != l_ext) begin
              if (can_emit) begin
                emit = 1'b1; e_fail = 1'b1; st_next = S_IDLE;
              end
            end else if (cs.count == '0) begin
              if (can_emit) begin
                emit              = 1'b1;
                e_fail            = 1'b1;
                cstat_we          = 1'b1;
                cstat_wdata       = cs;
                cstat_wdata.bound = NONE_LOCK;
                st_next           = S_IDLE;
              end
            end else begin
              tlast_next = 1'b0;
              tnext_next = S_SIG_OK;
              st_next    = S_POP_RD;
            end
          end
          OP_BROADCAST: begin
            if (cs.bound != l_ext) begin
              if (can_emit) begin
                emit = 1'b1; e_fail = 1'b1; st_next = S_IDLE;
              end
            end else begin
              st_next = S_BC_LOOP;
            end
          end
          default: st_next = S_IDLE;
        endcase
      end

      // Lock acquire on behalf of tw
      S_TAKE: begin
        if (ls.busy && ls.owner == tw) begin
          if (can_emit) begin
            emit = 1'b1; e_who = tw; e_last = tlast; st_next = tnext;
          end
        end else if (!ls.busy) begin
          if (can_emit) begin
            emit          = 1'b1;
            e_who         = tw;
            e_last        = tlast;
            ls_next.busy  = 1'b1;
            ls_next.owner = tw;
            st_next       = tnext;
          end
        end else if (ls.count < QD) begin
          lwait_we      = 1'b1;
          ls_next.count = ls.count + (QW + 1)'(1);
          st_next       = tnext;
        end else if (can_emit) begin
          emit = 1'b1; e_who = tw; e_fail = 1'b1; e_last = tlast; st_next = tnext;
        end
        // acquire finishes here: store the lock status once the step is done
        if (tnext == S_IDLE && st_next == S_IDLE) begin
          lstat_we    = 1'b1;
          lstat_wdata = ls_next;
        end
      end

      S_G_RD: st_next = S_G_DATA;

      // Head lock waiter becomes owner and gets its grant
      S_G_DATA: begin
        if (can_emit) begin
          emit          = 1'b1;
          e_who         = lwait_rdata;
          e_last        = glast;
          ls_next.owner = lwait_rdata;
          ls_next.head  = (ls.head == QD_LAST) ? '0 : ls.head + QW'(1);
          ls_next.count = ls.count - (QW + 1)'(1);
          st_next       = gnext;
        end
      end

      S_REL_OK: begin
        if (can_emit) begin
          emit     = 1'b1;
          lstat_we = 1'b1;
          st_next  = S_IDLE;
        end
      end

      S_POP_RD: st_next = S_POP_DATA;

      S_POP_DATA: begin
        tw_next       = cwait_rdata;
        cs_next.head  = (cs.head == QD_LAST) ? '0 : cs.head + QW'(1);
        cs_next.count = cs.count - (QW + 1)'(1);
        st_next       = S_TAKE;
      end

      // Final step of signal and wait: store both entries, signal replies
      S_SIG_OK: begin
        if (rq.op == OP_WAIT) begin
          lstat_we = 1'b1;
          cstat_we = 1'b1;
          st_next  = S_IDLE;
        end else if (can_emit) begin
          emit     = 1'b1;
          lstat_we = 1'b1;
          cstat_we = 1'b1;
          st_next  = S_IDLE;
        end
      end

      // Broadcast drains the condition queue one waiter at a time
      S_BC_LOOP: begin
        if (rq.op == OP_WAIT) begin
          st_next = S_SIG_OK;
        end else if (cs.count != '0) begin
          tlast_next = 1'b0;
          tnext_next = S_BC_LOOP;
          st_next    = S_POP_RD;
        end else if (can_emit) begin
          emit              = 1'b1;
          lstat_we          = 1'b1;
          cstat_we          = 1'b1;
          cstat_wdata       = cs;
          cstat_wdata.bound = NONE_LOCK;
          st_next           = S_IDLE;
        end
      end

      default: st_next = S_IDLE;
    endcase
  end

endmodule

FILE: hdl/queued_lock_and_condition_manager.sv
// Top level of the queued lock and condition manager.
//
//   channel   direction  handshake             payload
//   request   in         in_valid / in_stall   kind, client_machine, client_mailbox,
//                                               lock_index, cond_index, name_key
//   reply     out        out_valid / out_stall dest_machine, dest_mailbox, failed,
//                                               entry_index, last
//
// A request refused at the entry check is answered from the decode step; a release or
// wait that hands the lock over also sends a grant to the next lock waiter.
// Broadcast takes the condition waiters one at a time; create scans the entries by name
// until a match, up to all 16 with the default sizes.
// rst is synchronous; it clears the valid bits and the sequencer, tables need no sweep.
// A stalled reply holds the sequencer; up to two requests queue behind it.
module queued_lock_and_condition_manager #(
  parameter int NUM_LOCKS   = 16,
  parameter int NUM_CONDS   = 16,
  parameter int QUEUE_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [3:0]  kind,
  input  logic [7:0]  client_machine,
  input  logic [7:0]  client_mailbox,
  input  logic [7:0]  lock_index,
  input  logic [7:0]  cond_index,
  input  logic [31:0] name_key,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  dest_machine,
  output logic [7:0]  dest_mailbox,
  output logic        failed,
  output logic [3:0]  entry_index,
  output logic        last
);
  import qlcm_pkg::*;

  logic q_valid;
  logic q_pop;
  req_t q_req;

  qlcm_front #(.NUM_LOCKS(NUM_LOCKS), .NUM_CONDS(NUM_CONDS)) u_front (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .kind(kind), .client_machine(client_machine), .client_mailbox(client_mailbox),
    .lock_index(lock_index), .cond_index(cond_index), .name_key(name_key),
    .q_valid(q_valid), .q_req(q_req), .q_pop(q_pop)
  );

  qlcm_back #(
    .NUM_LOCKS(NUM_LOCKS), .NUM_CONDS(NUM_CONDS), .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_back (
    .clk(clk), .rst(rst),
    .q_valid(q_valid), .q_req(q_req), .q_pop(q_pop),
    .out_valid(out_valid), .out_stall(out_stall),
    .dest_machine(dest_machine), .dest_mailbox(dest_mailbox),
    .failed(failed), .entry_index(entry_index), .last(last)
  );

  // The back end only takes a request that the queue holds
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst) q_pop |-> q_valid)
    else $error("request popped from empty queue");

  // A full intake queue is never seen as empty by the back end
  a_stall_full: assert property (@(posedge clk) disable iff (rst) in_stall |-> q_valid)
    else $error("intake stalls with nothing queued");

  // A pop is never followed by another pop in the next cycle
  a_pop_spacing: assert property (@(posedge clk) disable iff (rst) q_pop |=> !q_pop)
    else $error("back-to-back pops");

endmodule

FILE: dv/tb_top.sv
// Self-checking testbench for the queued lock and condition manager.
module tb_top;
  import qlcm_pkg::*;

  localparam int NL = 16;
  localparam int NC = 16;
  localparam int QD = 16;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct packed {
    logic [3:0]  kind;
    logic [7:0]  mach;
    logic [7:0]  mbox;
    logic [7:0]  lidx;
    logic [7:0]  cidx;
    logic [31:0] key;
  } request_t;

  typedef struct packed {
    logic [7:0] mach;
    logic [7:0] mbox;
    logic       failed;
    logic [3:0] idx;
    logic       last;
  } reply_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [3:0]  kind = '0;
  logic [7:0]  client_machine = '0;
  logic [7:0]  client_mailbox = '0;
  logic [7:0]  lock_index = '0;
  logic [7:0]  cond_index = '0;
  logic [31:0] name_key = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  dest_machine;
  logic [7:0]  dest_mailbox;
  logic        failed;
  logic [3:0]  entry_index;
  logic        last;

  queued_lock_and_condition_manager u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .kind(kind), .client_machine(client_machine), .client_mailbox(client_mailbox),
    .lock_index(lock_index), .cond_index(cond_index), .name_key(name_key),
    .out_valid(out_valid), .out_stall(out_stall),
    .dest_machine(dest_machine), .dest_mailbox(dest_mailbox), .failed(failed),
    .entry_index(entry_index), .last(last)
  );

  always #2 clk = ~clk;

  // Shadow of the lock and condition tables
  logic        lk_valid [NL];
  logic [31:0] lk_name [NL];
  logic [7:0]  lk_refs [NL];
  logic        lk_busy [NL];
  logic [15:0] lk_owner [NL];
  logic [15:0] lk_q [NL][QD];
  int          lk_head [NL];
  int          lk_cnt [NL];
  logic        cv_valid [NC];
  logic [31:0] cv_name [NC];
  logic [7:0]  cv_refs [NC];
  int          cv_bound [NC];
  logic [15:0] cv_q [NC][QD];
  int          cv_head [NC];
  int          cv_cnt [NC];

  request_t pending_reqs[$];
  reply_t   expected_replies[$];
  reply_t   new_replies[$];
  int       idle_pct = 0;
  int       stall_pct = 0;
  bit       hold_sender = 1'b0;
  int       fail_count = 0;
  int       quiet_cycles = 0;

  function automatic void add_reply(logic [15:0] who, logic fl, int idx);
    reply_t r;
    r.mach = who[15:8];
    r.mbox = who[7:0];
    r.failed = fl;
    r.idx = idx[3:0];
    r.last = 1'b0;
    new_replies.push_back(r);
  endfunction

  function automatic void take_lock(int l, logic [15:0] who);
    if (lk_busy[l] && lk_owner[l] == who) begin
      add_reply(who, 1'b0, 0);
    end else if (!lk_busy[l]) begin
      lk_busy[l] = 1'b1;
      lk_owner[l] = who;
      add_reply(who, 1'b0, 0);
    end else if (lk_cnt[l] < QD) begin
      lk_q[l][(lk_head[l] + lk_cnt[l]) % QD] = who;
      lk_cnt[l]++;
    end else begin
      add_reply(who, 1'b1, 0);
    end
  endfunction

  function automatic bit give_lock(int l, logic [15:0] who);
    logic [15:0] nxt;
    if (!lk_busy[l] || lk_owner[l] != who) return 1'b0;
    if (lk_cnt[l] > 0) begin
      nxt = lk_q[l][lk_head[l]];
      lk_head[l] = (lk_head[l] + 1) % QD;
      lk_cnt[l]--;
      lk_owner[l] = nxt;
      add_reply(nxt, 1'b0, 0);
    end else begin
      lk_busy[l] = 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic logic [15:0] pop_cond(int c);
    logic [15:0] w;
    w = cv_q[c][cv_head[c]];
    cv_head[c] = (cv_head[c] + 1) % QD;
    cv_cnt[c]--;
    return w;
  endfunction

  function automatic void clear_tables();
    for (int i = 0; i < NL; i++) begin
      lk_valid[i] = 0; lk_refs[i] = 0; lk_busy[i] = 0; lk_head[i] = 0; lk_cnt[i] = 0;
      lk_name[i] = 0; lk_owner[i] = 0;
    end
    for (int i = 0; i < NC; i++) begin
      cv_valid[i] = 0; cv_refs[i] = 0; cv_head[i] = 0; cv_cnt[i] = 0;
      cv_bound[i] = NL; cv_name[i] = 0;
    end
  endfunction

  // Apply one request to the shadow tables and queue its replies
  function automatic void predict_replies(request_t q);
    logic [15:0] who;
    int l, c;
    bit done, ok;
    who = {q.mach, q.mbox};
    l = q.lidx;
    c = q.cidx;
    done = 1'b0;
    new_replies.delete();
    case (q.kind)
      OP_LOCK_CREATE, OP_COND_CREATE: begin
        for (int i = 0; i < 16 && !done; i++) begin
          if (q.kind == OP_LOCK_CREATE ? (lk_valid[i] && lk_name[i] == q.key)
                                       : (cv_valid[i] && cv_name[i] == q.key)) begin
            done = 1'b1;
            if (q.kind == OP_LOCK_CREATE) begin
              if (lk_refs[i] >= REFS_MAX) add_reply(who, 1'b1, 0);
              else begin lk_refs[i]++; add_reply(who, 1'b0, i); end
            end else begin
              if (cv_refs[i] >= REFS_MAX) add_reply(who, 1'b1, 0);
              else begin cv_refs[i]++; add_reply(who, 1'b0, i); end
            end
          end
        end
        for (int i = 0; i < 16 && !done; i++) begin
          if (q.kind == OP_LOCK_CREATE && !lk_valid[i]) begin
            lk_valid[i] = 1; lk_name[i] = q.key; lk_refs[i] = 1;
            lk_busy[i] = 0; lk_head[i] = 0; lk_cnt[i] = 0;
            add_reply(who, 1'b0, i);
            done = 1'b1;
          end else if (q.kind == OP_COND_CREATE && !cv_valid[i]) begin
            cv_valid[i] = 1; cv_name[i] = q.key; cv_refs[i] = 1;
            cv_bound[i] = NL; cv_head[i] = 0; cv_cnt[i] = 0;
            add_reply(who, 1'b0, i);
            done = 1'b1;
          end
        end
        if (!done) add_reply(who, 1'b1, 0);
      end
      OP_ACQUIRE, OP_RELEASE, OP_LOCK_DESTROY: begin
        if (l >= NL || !lk_valid[l]) add_reply(who, 1'b1, 0);
        else if (q.kind == OP_ACQUIRE) take_lock(l, who);
        else if (q.kind == OP_RELEASE) begin
          ok = give_lock(l, who);
          add_reply(who, !ok, 0);
        end else begin
          lk_refs[l]--;
          if (lk_refs[l] == 0) begin lk_valid[l] = 0; add_reply(who, 1'b0, 0); end
          else add_reply(who, 1'b1, 0);
        end
      end
      OP_COND_DESTROY: begin
        if (c >= NC || !cv_valid[c]) add_reply(who, 1'b1, 0);
        else begin
          cv_refs[c]--;
          if (cv_refs[c] == 0) begin cv_valid[c] = 0; add_reply(who, 1'b0, 0); end
          else add_reply(who, 1'b1, 0);
        end
      end
      OP_SIGNAL, OP_WAIT, OP_BROADCAST: begin
        if (l >= NL || c >= NC || !lk_valid[l] || !cv_valid[c]) add_reply(who, 1'b1, 0);
        else if (q.kind == OP_WAIT) begin
          if (cv_bound[c] == NL) cv_bound[c] = l;
          if (cv_bound[c] != l) add_reply(who, 1'b1, 0);
          else if (cv_cnt[c] >= QD) add_reply(who, 1'b1, 0);
          else begin
            cv_q[c][(cv_head[c] + cv_cnt[c]) % QD] = who;
            cv_cnt[c]++;
            ok = give_lock(l, who);
          end
        end else if (cv_bound[c] != l) add_reply(who, 1'b1, 0);
        else if (q.kind == OP_SIGNAL) begin
          if (cv_cnt[c] == 0) begin cv_bound[c] = NL; add_reply(who, 1'b1, 0); end
          else begin take_lock(l, pop_cond(c)); add_reply(who, 1'b0, 0); end
        end else begin
          while (cv_cnt[c] > 0) take_lock(l, pop_cond(c));
          cv_bound[c] = NL;
          add_reply(who, 1'b0, 0);
        end
      end
      default: ;
    endcase
    if (new_replies.size() > 0) new_replies[new_replies.size() - 1].last = 1'b1;
    foreach (new_replies[i]) expected_replies.push_back(new_replies[i]);
  endfunction

  // Driver: present requests, advance on acceptance
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) predict_replies(pending_reqs.pop_front());
      if (!(in_valid && in_stall)) begin
        if (pending_reqs.size() > 0 && !hold_sender && $urandom_range(99) >= idle_pct) begin
          request_t r;
          r = pending_reqs[0];
          in_valid <= 1'b1;
          kind <= r.kind; client_machine <= r.mach; client_mailbox <= r.mbox;
          lock_index <= r.lidx; cond_index <= r.cidx; name_key <= r.key;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Monitor: compare each reply with the oldest expectation
  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (out_valid && !out_stall) begin
        if (expected_replies.size() == 0) begin
          $error("unexpected reply to %0h:%0h", dest_machine, dest_mailbox);
          fail_count++;
        end else begin
          reply_t e;
          e = expected_replies.pop_front();
          if (dest_machine !== e.mach) begin
            $error("dest_machine exp %0h got %0h", e.mach, dest_machine); fail_count++;
          end
          if (dest_mailbox !== e.mbox) begin
            $error("dest_mailbox exp %0h got %0h", e.mbox, dest_mailbox); fail_count++;
          end
          if (failed !== e.failed) begin
            $error("failed exp %0h got %0h", e.failed, failed); fail_count++;
          end
          if (entry_index !== e.idx) begin
            $error("entry_index exp %0h got %0h", e.idx, entry_index); fail_count++;
          end
          if (last !== e.last) begin
            $error("last exp %0h got %0h", e.last, last); fail_count++;
          end
        end
      end
    end
  end

  // Watchdog on lack of progress
  always @(posedge clk) begin
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic request_t make_req(logic [3:0] k, int who, int l, int c, logic [31:0] key);
    request_t r;
    r.kind = k; r.mach = who[15:8]; r.mbox = who[7:0];
    r.lidx = l[7:0]; r.cidx = c[7:0]; r.key = key;
    return r;
  endfunction

  // Small client, index and key pools keep tables busy; rare wide values
  function automatic request_t rand_req();
    request_t r;
    int w;
    w = $urandom_range(99);
    if (w < 4) r.kind = 4'($urandom_range(15));
    else begin
      case ($urandom_range(9))
        0: r.kind = OP_LOCK_CREATE;
        1: r.kind = OP_COND_CREATE;
        2, 3: r.kind = OP_ACQUIRE;
        4: r.kind = OP_RELEASE;
        5: r.kind = OP_WAIT;
        6: r.kind = OP_SIGNAL;
        7: r.kind = OP_BROADCAST;
        8: r.kind = $urandom_range(1) ? OP_LOCK_DESTROY : OP_RELEASE;
        default: r.kind = $urandom_range(3) == 0 ? OP_COND_DESTROY : OP_ACQUIRE;
      endcase
    end
    if ($urandom_range(9) == 0) begin
      r.mach = 8'($urandom); r.mbox = 8'($urandom);
    end else begin
      r.mach = 8'($urandom_range(3)); r.mbox = 8'($urandom_range(3));
    end
    r.lidx = ($urandom_range(19) == 0) ? 8'($urandom) : 8'($urandom_range(3));
    r.cidx = ($urandom_range(19) == 0) ? 8'($urandom) : 8'($urandom_range(3));
    r.key = ($urandom_range(9) == 0) ? $urandom : 32'($urandom_range(5));
    return r;
  endfunction

  task automatic wait_drained();
    while (pending_reqs.size() > 0 || in_valid || expected_replies.size() > 0)
      @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  initial begin
    clear_tables();
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed: create, queueing, handoff, conditions, range and refusal cases
    pending_reqs.push_back(make_req(4'hF, 16'h0101, 0, 0, 0));
    pending_reqs.push_back(make_req(OP_LOCK_CREATE, 16'h0000, 0, 0, 32'hFFFF_FFFF));
    pending_reqs.push_back(make_req(OP_LOCK_CREATE, 16'hFFFF, 0, 0, 32'hFFFF_FFFF));
    pending_reqs.push_back(make_req(OP_COND_CREATE, 16'h0102, 0, 0, 32'h0));
    pending_reqs.push_back(make_req(OP_ACQUIRE, 16'h0101, 0, 0, 0));
    pending_reqs.push_back(make_req(OP_ACQUIRE, 16'h0101, 0, 0, 0));
    pending_reqs.push_back(make_req(OP_ACQUIRE, 16'h0202, 0, 0, 0));
    pending_reqs.push_back(make_req(OP_RELEASE, 16'h0303, 0, 0, 0));
    pending_reqs.push_back(make_req(OP_RELEASE, 16'h0101, 0, 0, 0));
    pending_reqs.push_back(make_req(OP_WAIT, 16'h0202, 0, 0, 0));
    pending_reqs.push_back(make_req(OP_WAIT, 16'h0303, 1, 0, 0));
    pending_reqs.push_back(make_req(OP_SIGNAL, 16'h0404, 0, 0, 0));
    pending_reqs.push_back(make_req(OP_SIGNAL, 16'h0404, 0, 0, 0));
    pending_reqs.push_back(make_req(OP_BROADCAST, 16'h0404, 0, 0, 0));
    pending_reqs.push_back(make_req(OP_ACQUIRE, 16'h0505, 255, 0, 0));
    pending_reqs.push_back(make_req(OP_WAIT, 16'h0505, 0, 16, 0));
    pending_reqs.push_back(make_req(OP_COND_DESTROY, 16'h0505, 0, 255, 0));
    pending_reqs.push_back(make_req(OP_LOCK_DESTROY, 16'h0505, 0, 0, 0));
    pending_reqs.push_back(make_req(OP_LOCK_DESTROY, 16'h0505, 0, 0, 0));
    pending_reqs.push_back(make_req(OP_COND_DESTROY, 16'h0505, 0, 0, 0));
    for (int i = 0; i < 17; i++)
      pending_reqs.push_back(make_req(OP_LOCK_CREATE, 16'h0606, 0, 0, 32'h100 + i));
    wait_drained();

    // Random phases with differing idle and stall mixes
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct  = (ph == 1 || ph == 3) ? 57 : (ph == 2 ? 0 : 0);
      stall_pct = (ph == 2) ? 57 : (ph == 3 ? 57 : 0);
      if (ph == 3) begin idle_pct = 19; stall_pct = 19; end
      // Fill the waiter queue of lock 1, then waits and a broadcast on condition 1
      if (ph == 0) begin
        pending_reqs.push_back(make_req(OP_ACQUIRE, 16'h0A0A, 1, 0, 0));
        for (int i = 0; i < 17; i++)
          pending_reqs.push_back(make_req(OP_ACQUIRE, 16'h1000 + i, 1, 0, 0));
        pending_reqs.push_back(make_req(OP_COND_CREATE, 16'h0A0A, 0, 0, 32'h77));
        for (int i = 0; i < 17; i++)
          pending_reqs.push_back(make_req(OP_WAIT, 16'h2000 + i, 1, 1, 0));
        pending_reqs.push_back(make_req(OP_BROADCAST, 16'h0A0A, 1, 1, 0));
      end
      for (int i = 0; i < 100; i++) pending_reqs.push_back(rand_req());
      if (ph == 1) begin
        hold_sender = 1'b1;
        while (in_valid || expected_replies.size() > 0) @(posedge clk);
        hold_sender = 1'b0;
      end
      wait_drained();
    end

    if (fail_count == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule
